FILE: rtl/core/svc_pkg.sv
// ----------------------------------------------------------------------------
// svc_pkg
// shared types, codes and constants of the stamp vending change controller
// ----------------------------------------------------------------------------
`default_nettype none

package svc_pkg;

  localparam int unsigned COIN_W   = 6;
  localparam int unsigned STOCK_W  = 8;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned INITIAL_FILL_DEFAULT = 10;

  // coin values and stamp prices
  localparam logic [COIN_W-1:0] VAL_50 = COIN_W'(50);
  localparam logic [COIN_W-1:0] VAL_25 = COIN_W'(25);
  localparam logic [COIN_W-1:0] VAL_15 = COIN_W'(15);
  localparam logic [COIN_W-1:0] VAL_10 = COIN_W'(10);
  localparam logic [COIN_W-1:0] VAL_5  = COIN_W'(5);

  typedef enum logic [STATUS_W-1:0] {
    ST_DISPENSED    = 3'd0,
    ST_INSUFFICIENT = 3'd1,
    ST_NO_PRICE     = 3'd2,
    ST_SOLD_OUT     = 3'd3,
    ST_NO_CHANGE    = 3'd4,
    ST_COIN_REJECT  = 3'd5
  } status_t;

  typedef struct packed {
    logic [STOCK_W-1:0] coin50;
    logic [STOCK_W-1:0] coin25;
    logic [STOCK_W-1:0] coin10;
    logic [STOCK_W-1:0] coin5;
    logic [STOCK_W-1:0] stamp25;
    logic [STOCK_W-1:0] stamp15;
    logic [STOCK_W-1:0] stamp10;
  } stock_t;

  typedef struct packed {
    status_t status;
    logic    give25;
    logic    give10;
    logic    give5;
  } sale_t;

endpackage

`default_nettype wire

FILE: rtl/core/svc_sale.sv
// ----------------------------------------------------------------------------
// svc_sale
// decision logic for one sale: checks, change flags and next stock counts
// ----------------------------------------------------------------------------
`default_nettype none

module svc_sale (
  input  wire logic [svc_pkg::COIN_W-1:0] coin,
  input  wire logic [svc_pkg::COIN_W-1:0] price,
  input  wire svc_pkg::stock_t            cur,
  output svc_pkg::sale_t                  res,
  output svc_pkg::stock_t                 nxt
);
  import svc_pkg::*;

  function automatic logic [STOCK_W-1:0] sat_inc(input logic [STOCK_W-1:0] v);
    sat_inc = (v == {STOCK_W{1'b1}}) ? v : v + STOCK_W'(1);
  endfunction

  logic [COIN_W-1:0]  change;
  logic [COIN_W-1:0]  rem1;
  logic [COIN_W-1:0]  rem2;
  logic               g25, g10, g5;
  logic               price_ok, coin_ok;
  logic [STOCK_W-1:0] stamp_cnt;
  logic               no_change;
  logic               ok;
  status_t            st;

  assign price_ok = (price == VAL_25) || (price == VAL_15) || (price == VAL_10);
  assign coin_ok  = (coin == VAL_50) || (coin == VAL_25) || (coin == VAL_10) ||
                    (coin == VAL_5);

  // greedy change, at most one coin of each kind
  assign change = coin - price;
  assign g25    = (change >= VAL_25);
  assign rem1   = g25 ? change - VAL_25 : change;
  assign g10    = (rem1 >= VAL_10);
  assign rem2   = g10 ? rem1 - VAL_10 : rem1;
  assign g5     = (rem2 >= VAL_5);

  always_comb begin
    if (price == VAL_25) begin
      stamp_cnt = cur.stamp25;
    end else if (price == VAL_15) begin
      stamp_cnt = cur.stamp15;
    end else begin
      stamp_cnt = cur.stamp10;
    end
  end

  assign no_change = (g25 && (cur.coin25 == '0)) || (g10 && (cur.coin10 == '0)) ||
                     (g5 && (cur.coin5 == '0));

  always_comb begin
    if (price > coin) begin
      st = ST_INSUFFICIENT;
    end else if (!price_ok) begin
      st = ST_NO_PRICE;
    end else if (!coin_ok) begin
      st = ST_COIN_REJECT;
    end else if (stamp_cnt == '0) begin
      st = ST_SOLD_OUT;
    end else if (no_change) begin
      st = ST_NO_CHANGE;
    end else begin
      st = ST_DISPENSED;
    end
  end

  assign ok  = (st == ST_DISPENSED);
  assign res = {st, ok && g25, ok && g10, ok && g5};

  // banked coin and paid change never hit the same stock
  always_comb begin
    nxt = cur;
    if (ok) begin
      if (price == VAL_25) begin
        nxt.stamp25 = cur.stamp25 - STOCK_W'(1);
      end else if (price == VAL_15) begin
        nxt.stamp15 = cur.stamp15 - STOCK_W'(1);
      end else begin
        nxt.stamp10 = cur.stamp10 - STOCK_W'(1);
      end
      if (g25) begin
        nxt.coin25 = cur.coin25 - STOCK_W'(1);
      end
      if (g10) begin
        nxt.coin10 = cur.coin10 - STOCK_W'(1);
      end
      if (g5) begin
        nxt.coin5 = cur.coin5 - STOCK_W'(1);
      end
      if (coin == VAL_50) begin
        nxt.coin50 = sat_inc(cur.coin50);
      end else if (coin == VAL_25) begin
        nxt.coin25 = sat_inc(cur.coin25);
      end else if (coin == VAL_10) begin
        nxt.coin10 = sat_inc(cur.coin10);
      end else begin
        nxt.coin5 = sat_inc(cur.coin5);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/svc_stock.sv
// ----------------------------------------------------------------------------
// svc_stock
// the seven stock counters, filled on reset and loaded once per sale
// ----------------------------------------------------------------------------
`default_nettype none

module svc_stock #(
  parameter int unsigned INITIAL_FILL = svc_pkg::INITIAL_FILL_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            update,
  input  wire svc_pkg::stock_t stock_next,
  output svc_pkg::stock_t      stock
);
  import svc_pkg::*;

  localparam logic [STOCK_W-1:0] FILL = STOCK_W'(INITIAL_FILL);

  always_ff @(posedge clk) begin
    if (rst) begin
      stock <= '{FILL, FILL, FILL, FILL, FILL, FILL, FILL};
    end else if (update) begin
      stock <= stock_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/stamp_vending_change_controller_top.sv
// ----------------------------------------------------------------------------
// stamp_vending_change_controller_top
// stamp vending controller with fixed change and coin/stamp stock counts
// ----------------------------------------------------------------------------
// One sale per item: a coin value and a stamp price go in, one result comes
// out with a status code, three change flags and all seven stock counts as
// they stand after the sale. Items flow at one per cycle while the output
// side takes them: an input register holds the sale, and the decision and the
// stock update happen in the cycle it moves into the result register. The
// stock counters are the only loop, and they close in that cycle, so a sale
// sees every earlier sale. Stocks start at INITIAL_FILL after reset.
`default_nettype none

module stamp_vending_change_controller_top #(
  parameter int unsigned INITIAL_FILL = svc_pkg::INITIAL_FILL_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [svc_pkg::COIN_W-1:0]   coin_amount,
  input  wire logic [svc_pkg::COIN_W-1:0]   stamp_price,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [svc_pkg::STATUS_W-1:0]      status,
  output logic                              give_coin25,
  output logic                              give_coin10,
  output logic                              give_coin5,
  output logic [svc_pkg::STOCK_W-1:0]       stock_coin50,
  output logic [svc_pkg::STOCK_W-1:0]       stock_coin25,
  output logic [svc_pkg::STOCK_W-1:0]       stock_coin10,
  output logic [svc_pkg::STOCK_W-1:0]       stock_coin5,
  output logic [svc_pkg::STOCK_W-1:0]       stock_stamp25,
  output logic [svc_pkg::STOCK_W-1:0]       stock_stamp15,
  output logic [svc_pkg::STOCK_W-1:0]       stock_stamp10
);
  import svc_pkg::*;

  // input register
  logic              in_full;
  logic [COIN_W-1:0] coin;
  logic [COIN_W-1:0] price;

  // result register
  sale_t  res;
  stock_t res_stock;

  // current stocks and the outcome of the held sale
  stock_t stock;
  stock_t stock_next;
  sale_t  sale;

  logic advance;

  // the held sale moves on when the result slot is free or being emptied
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      coin  <= coin_amount;
      price <= stamp_price;
    end
  end

  svc_sale u_sale (
    .coin  (coin),
    .price (price),
    .cur   (stock),
    .res   (sale),
    .nxt   (stock_next)
  );

  // stock is committed in the same cycle the result is captured
  svc_stock #(
    .INITIAL_FILL (INITIAL_FILL)
  ) u_stock (
    .clk        (clk),
    .rst        (rst),
    .update     (advance),
    .stock_next (stock_next),
    .stock      (stock)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res       <= sale;
      res_stock <= stock_next;
    end
  end

  assign status        = res.status;
  assign give_coin25   = res.give25;
  assign give_coin10   = res.give10;
  assign give_coin5    = res.give5;
  assign stock_coin50  = res_stock.coin50;
  assign stock_coin25  = res_stock.coin25;
  assign stock_coin10  = res_stock.coin10;
  assign stock_coin5   = res_stock.coin5;
  assign stock_stamp25 = res_stock.stamp25;
  assign stock_stamp15 = res_stock.stamp15;
  assign stock_stamp10 = res_stock.stamp10;

`ifndef SYNTHESIS
  // a sale that moves on always lands in the result register
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("held sale lost on its way to the result register");

  // a failed sale pays no change
  a_fail_no_change: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (res.status != ST_DISPENSED)) |->
      (!res.give25 && !res.give10 && !res.give5))
    else $error("change paid on a failed sale");

  // the reported stocks are the live counters once the sale is committed
  a_stock_matches: assert property (@(posedge clk) disable iff (rst)
    advance |=> (res_stock == stock))
    else $error("reported stock differs from committed stock");

  // stocks only change when a sale moves on
  a_stock_stable: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(stock))
    else $error("stock changed without a sale");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_stamp_vending_change_controller_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stamp_vending_change_controller_top
// self-checking bench for the stamp vending change controller
// ----------------------------------------------------------------------------
// Sales go in through the valid/ready input channel. Each accepted item is
// run through a local model of the vending rules, which keeps its own copy of
// the seven stock counts. The expected result is queued, and every result the
// block hands out is compared field by field with the oldest queued entry.
// Directed tests cover the field extremes, each failure code and the whole
// change table. They then drain one stamp price and the 25 coins, so that
// both the no-change and the sold-out cases are reached. Random sales
// follow, mostly well-formed with some noise, over several idling mixes, a
// long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------

module tb_stamp_vending_change_controller_top;
  import svc_pkg::*;

  localparam int unsigned FILL       = INITIAL_FILL_DEFAULT;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam int unsigned PRINT_CAP  = 40;
  localparam int unsigned RAND_SALES = 500;

  localparam logic [STOCK_W-1:0] FILL_COUNT = STOCK_W'(FILL);

  // expected result of one sale: decision plus every stock count after it
  typedef struct packed {
    sale_t  sale;
    stock_t stock;
  } sale_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [COIN_W-1:0] coin_amount = '0;
  logic [COIN_W-1:0] stamp_price = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;

  logic [STATUS_W-1:0] status;
  logic                give_coin25;
  logic                give_coin10;
  logic                give_coin5;
  logic [STOCK_W-1:0]  stock_coin50;
  logic [STOCK_W-1:0]  stock_coin25;
  logic [STOCK_W-1:0]  stock_coin10;
  logic [STOCK_W-1:0]  stock_coin5;
  logic [STOCK_W-1:0]  stock_stamp25;
  logic [STOCK_W-1:0]  stock_stamp15;
  logic [STOCK_W-1:0]  stock_stamp10;

  // model copy of the machine's stock, same fill as the block after reset
  stock_t vend_stock = '{coin50: FILL_COUNT, coin25: FILL_COUNT, coin10: FILL_COUNT,
                         coin5: FILL_COUNT, stamp25: FILL_COUNT, stamp15: FILL_COUNT,
                         stamp10: FILL_COUNT};

  sale_result_t expected_sales[$];

  int unsigned cycle          = 0;
  int unsigned hold_until     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;

  stamp_vending_change_controller_top #(
    .INITIAL_FILL(FILL)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .coin_amount  (coin_amount),
    .stamp_price  (stamp_price),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .give_coin25  (give_coin25),
    .give_coin10  (give_coin10),
    .give_coin5   (give_coin5),
    .stock_coin50 (stock_coin50),
    .stock_coin25 (stock_coin25),
    .stock_coin10 (stock_coin10),
    .stock_coin5  (stock_coin5),
    .stock_stamp25(stock_stamp25),
    .stock_stamp15(stock_stamp15),
    .stock_stamp10(stock_stamp10)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // vending rules
  // ---------------------------------------------------------------------------

  // a banked coin saturates rather than wrapping
  function automatic logic [STOCK_W-1:0] banked(input logic [STOCK_W-1:0] count);
    return (count == '1) ? count : count + STOCK_W'(1);
  endfunction

  // decide one sale and move the local stock on, in the block's check order
  function automatic sale_result_t predict_sale(input logic [COIN_W-1:0] coin,
                                                input logic [COIN_W-1:0] price);
    sale_result_t       res;
    logic [COIN_W-1:0]  change;
    logic [STOCK_W-1:0] stamps_left;
    logic               g25;
    logic               g10;
    logic               g5;
    res.sale.status = ST_DISPENSED;
    res.sale.give25 = 1'b0;
    res.sale.give10 = 1'b0;
    res.sale.give5  = 1'b0;
    if (price > coin) begin
      res.sale.status = ST_INSUFFICIENT;
    end else if (price != VAL_25 && price != VAL_15 && price != VAL_10) begin
      res.sale.status = ST_NO_PRICE;
    end else if (coin != VAL_50 && coin != VAL_25 && coin != VAL_10 && coin != VAL_5) begin
      res.sale.status = ST_COIN_REJECT;
    end else begin
      // change is paid greedily, at most one coin of each kind
      change = coin - price;
      g25 = (change >= VAL_25);
      if (g25) change = change - VAL_25;
      g10 = (change >= VAL_10);
      if (g10) change = change - VAL_10;
      g5 = (change >= VAL_5);
      case (price)
        VAL_25:  stamps_left = vend_stock.stamp25;
        VAL_15:  stamps_left = vend_stock.stamp15;
        default: stamps_left = vend_stock.stamp10;
      endcase
      if (stamps_left == '0) begin
        res.sale.status = ST_SOLD_OUT;
      end else if ((g25 && vend_stock.coin25 == '0) || (g10 && vend_stock.coin10 == '0) ||
                   (g5 && vend_stock.coin5 == '0)) begin
        res.sale.status = ST_NO_CHANGE;
      end else begin
        case (price)
          VAL_25:  vend_stock.stamp25 = vend_stock.stamp25 - STOCK_W'(1);
          VAL_15:  vend_stock.stamp15 = vend_stock.stamp15 - STOCK_W'(1);
          default: vend_stock.stamp10 = vend_stock.stamp10 - STOCK_W'(1);
        endcase
        if (g25) vend_stock.coin25 = vend_stock.coin25 - STOCK_W'(1);
        if (g10) vend_stock.coin10 = vend_stock.coin10 - STOCK_W'(1);
        if (g5)  vend_stock.coin5  = vend_stock.coin5 - STOCK_W'(1);
        // tendered coin goes into the bank after change is taken out
        case (coin)
          VAL_50:  vend_stock.coin50 = banked(vend_stock.coin50);
          VAL_25:  vend_stock.coin25 = banked(vend_stock.coin25);
          VAL_10:  vend_stock.coin10 = banked(vend_stock.coin10);
          default: vend_stock.coin5  = banked(vend_stock.coin5);
        endcase
        res.sale.give25 = g25;
        res.sale.give10 = g10;
        res.sale.give5  = g5;
      end
    end
    res.stock = vend_stock;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("mismatch on %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle);
  endtask

  task automatic check_sale_result();
    sale_result_t want;
    if (expected_sales.size() == 0) begin
      report_mismatch("result with no sale pending", int'(status), 0);
      return;
    end
    want = expected_sales.pop_front();
    if (status !== want.sale.status)
      report_mismatch("status", int'(status), int'(want.sale.status));
    if (give_coin25 !== want.sale.give25)
      report_mismatch("give_coin25", int'(give_coin25), int'(want.sale.give25));
    if (give_coin10 !== want.sale.give10)
      report_mismatch("give_coin10", int'(give_coin10), int'(want.sale.give10));
    if (give_coin5 !== want.sale.give5)
      report_mismatch("give_coin5", int'(give_coin5), int'(want.sale.give5));
    if (stock_coin50 !== want.stock.coin50)
      report_mismatch("stock_coin50", int'(stock_coin50), int'(want.stock.coin50));
    if (stock_coin25 !== want.stock.coin25)
      report_mismatch("stock_coin25", int'(stock_coin25), int'(want.stock.coin25));
    if (stock_coin10 !== want.stock.coin10)
      report_mismatch("stock_coin10", int'(stock_coin10), int'(want.stock.coin10));
    if (stock_coin5 !== want.stock.coin5)
      report_mismatch("stock_coin5", int'(stock_coin5), int'(want.stock.coin5));
    if (stock_stamp25 !== want.stock.stamp25)
      report_mismatch("stock_stamp25", int'(stock_stamp25), int'(want.stock.stamp25));
    if (stock_stamp15 !== want.stock.stamp15)
      report_mismatch("stock_stamp15", int'(stock_stamp15), int'(want.stock.stamp15));
    if (stock_stamp10 !== want.stock.stamp10)
      report_mismatch("stock_stamp10", int'(stock_stamp10), int'(want.stock.stamp10));
  endtask

  // output side: samples at the edge, then picks ready for the next cycle;
  // a pending hold-off keeps ready low until the cycle count passes it
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_sale_result();
    if (cycle < hold_until) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // offer one sale, with a random idle gap first; valid is left high after
  // acceptance so that back-to-back items never lower and raise it in one step
  task automatic offer_sale(input logic [COIN_W-1:0] coin, input logic [COIN_W-1:0] price);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    coin_amount <= coin;
    stamp_price <= price;
    do @(posedge clk); while (!in_ready);
    expected_sales.push_back(predict_sale(coin, price));
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_all_sales_out();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_sales.size() != 0) @(posedge clk);
  endtask

  // mostly real coins and prices, now and then any 6-bit value
  task automatic offer_random_sale();
    logic [COIN_W-1:0] coin_set[4];
    logic [COIN_W-1:0] price_set[3];
    logic [COIN_W-1:0] coin;
    logic [COIN_W-1:0] price;
    coin_set  = '{VAL_50, VAL_25, VAL_10, VAL_5};
    price_set = '{VAL_25, VAL_15, VAL_10};
    if ($urandom_range(99) < 85) coin = coin_set[2'($urandom_range(3))];
    else coin = COIN_W'($urandom_range(63));
    if ($urandom_range(99) < 85) price = price_set[2'($urandom_range(2))];
    else price = COIN_W'($urandom_range(63));
    offer_sale(coin, price);
  endtask

  // field extremes and every failure ahead of the stock checks
  task automatic test_rejections();
    send_idle_pct = 0;
    offer_sale(6'd0, 6'd0);      // no such price, all bits low
    offer_sale(6'd63, 6'd63);    // no such price, all bits high
    offer_sale(6'd0, 6'd63);     // insufficient
    offer_sale(VAL_5, VAL_10);   // a 5 coin never covers a real price
    offer_sale(6'd63, VAL_25);   // odd coin value rejected
    offer_sale(6'd30, VAL_10);   // odd coin value rejected
    offer_sale(VAL_50, VAL_5);   // 5 is not a stamp price
  endtask

  // every row of the change table
  task automatic test_change_table();
    offer_sale(VAL_10, VAL_10);
    offer_sale(VAL_25, VAL_25);
    offer_sale(VAL_25, VAL_15);
    offer_sale(VAL_25, VAL_10);
    offer_sale(VAL_50, VAL_25);
    offer_sale(VAL_50, VAL_15);
    offer_sale(VAL_50, VAL_10);
  endtask

  // empty the 25 coins and the price 25 stamps, then ask for both
  task automatic test_no_change_sold_out();
    repeat (8) offer_sale(VAL_50, VAL_25);
    repeat (3) offer_sale(VAL_50, VAL_15);
    offer_sale(VAL_50, VAL_25);
    wait_all_sales_out();
  endtask

  task automatic test_random_sales(input int unsigned count, input int unsigned idle_pct,
                                   input int unsigned stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    repeat (count) offer_random_sale();
  endtask

  // long output hold-off while sales keep coming, so the input side backs up
  task automatic test_back_pressure();
    send_idle_pct = 0;
    hold_until <= cycle + 150;
    repeat (30) offer_random_sale();
    wait_all_sales_out();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_rejections();
    test_change_table();
    test_no_change_sold_out();

    test_random_sales(RAND_SALES, 0, 0);
    test_random_sales(RAND_SALES, 80, 0);
    test_back_pressure();
    test_random_sales(RAND_SALES, 0, 80);
    test_random_sales(RAND_SALES, 36, 36);

    // drain with the output side always ready, then watch for strays
    recv_stall_pct <= 0;
    wait_all_sales_out();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_sales.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/svc_pkg.sv
rtl/core/svc_sale.sv
rtl/core/svc_stock.sv
rtl/core/stamp_vending_change_controller_top.sv
tb/sv/tb_stamp_vending_change_controller_top.sv
